// ===== src/assert_macros.svh =====
// Assertion macros shared by the pooled FIFO RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define PFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pooled FIFO assertion failed");

// Check the consequent in the cycle after the antecedent.
`define PFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pooled FIFO assertion failed");

`endif

// ===== src/pfr_pkg.sv =====
// Types and constants of the pooled FIFO with remove.
`timescale 1ns / 1ps

package pfr_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CAP_W      = 5;
  localparam int CNT_W      = 5;
  localparam int ACT_W      = 2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } pfr_action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_REPORT
  } pfr_state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_SHIFT,
    CELL_CLEAR
  } pfr_cell_op_e;

  typedef struct packed {
    logic [ACT_W-1:0]      action;
    logic [DATA_WIDTH-1:0] value;
  } pfr_in_t;

  typedef struct packed {
    logic                  status;
    logic [DATA_WIDTH-1:0] popped_value;
    logic [DATA_WIDTH-1:0] head_value;
    logic                  head_valid;
    logic [CNT_W-1:0]      count;
  } pfr_out_t;

  // Broadcast command from the controller to every cell.
  typedef struct packed {
    pfr_cell_op_e          op;
    logic [DATA_WIDTH-1:0] data;
  } pfr_cmd_t;

  // Contents of one cell as seen by its neighbours.
  typedef struct packed {
    logic                  valid;
    logic [DATA_WIDTH-1:0] data;
  } pfr_slot_t;

  // Search token walking down the chain; shf marks that a match was taken.
  typedef struct packed {
    logic tok;
    logic shf;
  } pfr_tok_t;

endpackage

// ===== src/pfr_cell.sv =====
// One storage cell of the pooled FIFO chain.
`timescale 1ns / 1ps

module pfr_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfr_pkg::pfr_cmd_t  cmd_i,
  input  logic              prev_valid_i,
  input  pfr_pkg::pfr_slot_t next_i,
  input  pfr_pkg::pfr_tok_t  tok_i,
  output pfr_pkg::pfr_slot_t slot_o,
  output pfr_pkg::pfr_tok_t  tok_o
);
  import pfr_pkg::*;

  logic                  valid_q, valid_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  pfr_tok_t              tok_q;
  logic                  hit;

  // Close the gap: either the match sits here or one was taken upstream.
  assign hit = tok_q.tok && (tok_q.shf || (valid_q && (data_q == cmd_i.data)));

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    case (cmd_i.op)
      CELL_HOLD: begin
        if (hit) begin
          valid_d = next_i.valid;
          data_d  = next_i.data;
        end
      end
      CELL_PUSH: begin
        if (!valid_q && prev_valid_i) begin
          valid_d = 1'b1;
          data_d  = cmd_i.data;
        end
      end
      CELL_SHIFT: begin
        valid_d = next_i.valid;
        data_d  = next_i.data;
      end
      CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign slot_o.valid = valid_q;
  assign slot_o.data  = data_q;
  assign tok_o.tok    = tok_q.tok;
  assign tok_o.shf    = tok_q.shf | hit;

endmodule

// ===== src/pfr_ctrl.sv =====
// Sequencer, count and output register of the pooled FIFO.
`timescale 1ns / 1ps

module pfr_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pfr_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  pfr_pkg::pfr_in_t           in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output pfr_pkg::pfr_out_t          out_data_o,
  output pfr_pkg::pfr_cmd_t          cmd_o,
  output pfr_pkg::pfr_tok_t          tok_o,
  input  pfr_pkg::pfr_tok_t          tok_i,
  input  pfr_pkg::pfr_slot_t         head_i
);
  import pfr_pkg::*;

  pfr_state_e            state_q, state_d;
  logic [CAP_W-1:0]      cap_q, cap_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic                  status_q, status_d;
  logic [DATA_WIDTH-1:0] popped_q, popped_d;
  logic                  out_valid_q, out_valid_d;
  pfr_out_t              out_q, out_d;
  logic [CAP_W-1:0]      cap_eff;
  logic                  accept, out_free, have_cap;
  pfr_action_e           act;

  assign cap_eff  = (cap_q > CAP_W'(POOL_DEPTH)) ? CAP_W'(POOL_DEPTH) : cap_q;
  assign have_cap = (cap_eff != '0);
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign act      = pfr_action_e'(in_data_i.action);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (have_cap && (act == ACT_REMOVE) && (count_q != '0)) begin
            state_d = ST_SWEEP;
          end else begin
            state_d = ST_REPORT;
          end
        end
      end
      ST_SWEEP: begin
        if (tok_i.tok) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands, counters and result.
  always_comb begin
    cap_d       = cap_q;
    count_d     = count_q;
    key_d       = key_q;
    status_d    = status_q;
    popped_d    = popped_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = CELL_HOLD;
    cmd_o.data  = key_q;
    tok_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          status_d = STATUS_FAIL;
          popped_d = '0;
          if (have_cap) begin
            case (act)
              ACT_PUSH: begin
                cmd_o.data = in_data_i.value;
                if (CAP_W'(count_q) < cap_eff) begin
                  cmd_o.op = CELL_PUSH;
                  count_d  = count_q + CNT_W'(1);
                  status_d = STATUS_OK;
                end
              end
              ACT_POP: begin
                if (count_q != '0) begin
                  cmd_o.op = CELL_SHIFT;
                  popped_d = head_i.data;
                  count_d  = count_q - CNT_W'(1);
                  status_d = STATUS_OK;
                end
              end
              ACT_REMOVE: begin
                key_d = in_data_i.value;
                if (count_q != '0) begin
                  tok_o.tok = 1'b1;
                end
              end
              ACT_CLEAR: begin
                cmd_o.op = CELL_CLEAR;
                count_d  = '0;
                status_d = STATUS_OK;
              end
              default: begin
                status_d = STATUS_FAIL;
              end
            endcase
          end
        end
      end
      ST_SWEEP: begin
        if (tok_i.tok) begin
          status_d = tok_i.shf ? STATUS_OK : STATUS_FAIL;
          if (tok_i.shf) begin
            count_d = count_q - CNT_W'(1);
          end
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.status       = status_q;
          out_d.popped_value = popped_q;
          out_d.head_valid   = (count_q != '0);
          out_d.head_value   = head_i.valid ? head_i.data : '0;
          out_d.count        = count_q;
        end
      end
      default: begin
        out_d = out_q;
      end
    endcase
    if (cfg_we_i) begin
      cap_d    = cfg_wdata_i;
      count_d  = '0;
      cmd_o.op = CELL_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    status_q <= status_d;
    popped_q <= popped_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/pooled_fifo_with_remove.sv =====
// Top level of the pooled FIFO with remove-by-value.
`timescale 1ns / 1ps

// A bounded FIFO of up to POOL_DEPTH entries held in a row of cells, head in
// cell 0 and entries packed towards it. Each transaction on the input channel
// carries an action (push, pop, remove first match, clear) and a value, and
// gives exactly one result transaction: status, popped value, head value and
// flag, and entry count after the action. The capacity register limits how
// many cells are in use; at zero every action fails, and writing it empties
// the queue. Push, pop, clear and any action that fails at once (zero
// capacity, or a remove on an empty queue) go from acceptance through the
// report state to the output register; a remove on a non-empty queue first
// waits in the sweep state while a search token walks the chain one cell per
// cycle, and the cell holding the first match and each cell the token passes
// after it take over the contents of their downstream neighbours. The input
// stalls from acceptance until the result is registered. A new transaction
// is taken while the previous result still waits for the sink; its own
// result then holds until the sink drains the output register.
// No memory needs clearing after reset.
module pooled_fifo_with_remove (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pfr_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  pfr_pkg::pfr_in_t           in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output pfr_pkg::pfr_out_t          out_data_o
);
  import pfr_pkg::*;

  `include "assert_macros.svh"

  pfr_cmd_t              cmd;
  pfr_slot_t             slot_w [POOL_DEPTH];
  pfr_tok_t              tok_w  [POOL_DEPTH+1];
  logic [POOL_DEPTH-1:0] valid_vec;
  logic [POOL_DEPTH-1:0] tok_vec;

  // Controller: decode the transaction, keep count and capacity, hold result.
  pfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_o       (cmd),
    .tok_o       (tok_w[0]),
    .tok_i       (tok_w[POOL_DEPTH]),
    .head_i      (slot_w[0])
  );

  // Chain of cells: each sees its upstream valid and its downstream contents.
  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
    logic      prev_valid;
    pfr_slot_t next_slot;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_valid = slot_w[i-1].valid;
    end

    // The last cell pulls in an empty slot when the chain closes up.
    if (i == POOL_DEPTH - 1) begin : g_last
      assign next_slot = '0;
    end else begin : g_inner
      assign next_slot = slot_w[i+1];
    end

    pfr_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_valid_i (prev_valid),
      .next_i       (next_slot),
      .tok_i        (tok_w[i]),
      .slot_o       (slot_w[i]),
      .tok_o        (tok_w[i+1])
    );

    assign valid_vec[i] = slot_w[i].valid;
    assign tok_vec[i]   = tok_w[i+1].tok;
  end

  // At most one search token is in flight.
  `PFR_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_vec))
  // Occupied cells stay packed towards the head.
  `PFR_ASSERT_NOW(a_packed, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0)
  // A walking token keeps the input side stalled.
  `PFR_ASSERT_NOW(a_sweep_stalls, tok_vec != '0, in_stall_o)
  // A freshly offered count agrees with the occupied cells.
  `PFR_ASSERT_NOW(a_count_cells, $rose(out_valid_o) && !$past(cfg_we_i),
                  32'(out_data_o.count) == $countones(valid_vec))

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the pooled FIFO with remove-by-value.
`timescale 1ns / 1ps

module tb;
  import pfr_pkg::*;

  // Clock, reset and the ports of the block under test.
  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  pfr_in_t          in_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  pfr_out_t         out_data_o;

  // Transactions waiting to be offered, and results still owed by the block.
  pfr_in_t  pending_items[$];
  pfr_out_t awaited_results[$];

  // Shadow of the queue contents, head first, and of the capacity register.
  logic [DATA_WIDTH-1:0] held_values[$];
  logic [CAP_W-1:0]      fifo_cap = '0;

  // Random values are mostly drawn from a small set so that removes hit.
  logic [DATA_WIDTH-1:0] value_pool[8];

  // Traffic shaping: calm_phase suppresses random idling on both sides,
  // rx_hold makes the sink refuse results for a long stretch.
  logic calm_phase = 1'b0;
  logic rx_hold = 1'b0;

  int unsigned fault_count = 0;
  int unsigned items_taken = 0;
  int unsigned results_checked = 0;
  int unsigned ok_total = 0;
  int unsigned fail_total = 0;
  int unsigned mid_cap = 0;

  pooled_fifo_with_remove uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Work out the result of one action and advance the shadow queue. Entries
  // leave in arrival order whatever slot they sat in, so an ordered list of
  // values is all the state the outputs depend on.
  function automatic pfr_out_t apply_action(input pfr_in_t item);
    pfr_out_t res;
    int       room;
    int       hit;
    res = '0;
    res.status = STATUS_FAIL;
    // A capacity beyond the pool behaves as the full pool.
    room = (int'(fifo_cap) > POOL_DEPTH) ? POOL_DEPTH : int'(fifo_cap);
    // With no capacity every action fails and nothing moves.
    if (room != 0) begin
      case (pfr_action_e'(item.action))
        ACT_PUSH: begin
          if (held_values.size() < room) begin
            held_values.push_back(item.value);
            res.status = STATUS_OK;
          end
        end
        ACT_POP: begin
          if (held_values.size() != 0) begin
            res.popped_value = held_values.pop_front();
            res.status = STATUS_OK;
          end
        end
        ACT_REMOVE: begin
          // Take only the first match, searching from the head.
          hit = -1;
          foreach (held_values[i]) begin
            if (hit < 0 && held_values[i] == item.value) hit = i;
          end
          if (hit >= 0) begin
            held_values.delete(hit);
            res.status = STATUS_OK;
          end
        end
        default: begin
          // Clear succeeds even on an empty queue.
          held_values.delete();
          res.status = STATUS_OK;
        end
      endcase
    end
    res.head_valid = (held_values.size() != 0);
    res.head_value = res.head_valid ? held_values[0] : '0;
    res.count = CNT_W'(held_values.size());
    return res;
  endfunction

  // Driver: note the transaction accepted at this edge, predict its result,
  // then hold the payload while stalled or offer the next pending item.
  always @(posedge clk_i) begin
    logic     taken;
    logic     nxt_valid;
    pfr_in_t  nxt_data;
    pfr_out_t want;
    if (rst_ni) begin
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        want = apply_action(in_data_i);
        awaited_results.push_back(want);
        items_taken++;
        if (want.status == STATUS_OK) ok_total++;
        else fail_total++;
      end
      nxt_valid = in_valid_i;
      nxt_data = in_data_i;
      if (!in_valid_i || taken) begin
        nxt_valid = 1'b0;
        // Idle in roughly a fifth of the cycles unless the phase is calm.
        if (pending_items.size() != 0 && (calm_phase || $urandom_range(0, 99) >= 20)) begin
          nxt_data = pending_items.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid_i <= nxt_valid;
      in_data_i <= nxt_data;
    end
  end

  // Monitor: compare each result transaction with the oldest prediction,
  // then decide whether the sink stalls in the next cycle.
  always @(posedge clk_i) begin
    pfr_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with no prediction waiting");
          fault_count++;
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_o.status);
            fault_count++;
          end
          if (out_data_o.popped_value !== want.popped_value) begin
            $error("popped_value: expected %0h, got %0h",
                   want.popped_value, out_data_o.popped_value);
            fault_count++;
          end
          if (out_data_o.head_value !== want.head_value) begin
            $error("head_value: expected %0h, got %0h",
                   want.head_value, out_data_o.head_value);
            fault_count++;
          end
          if (out_data_o.head_valid !== want.head_valid) begin
            $error("head_valid: expected %0d, got %0d",
                   want.head_valid, out_data_o.head_valid);
            fault_count++;
          end
          if (out_data_o.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_data_o.count);
            fault_count++;
          end
        end
      end
      out_stall_i <= rx_hold || (!calm_phase && $urandom_range(0, 99) < 20);
    end
  end

  // Wait, sampling between edges, until nothing is pending, offered or owed.
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || awaited_results.size() != 0);
  endtask

  // Write the capacity while the block is idle; this empties the queue.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_quiet();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    fifo_cap = cap;
    held_values.delete();
    @(negedge clk_i);
  endtask

  task automatic queue_item(input pfr_action_e act, input logic [DATA_WIDTH-1:0] val);
    pfr_in_t item;
    item.action = act;
    item.value = val;
    pending_items.push_back(item);
  endtask

  // Queue n random transactions; push_pct steers how full the queue runs.
  task automatic queue_random(input int n, input int push_pct);
    pfr_action_e           act;
    logic [DATA_WIDTH-1:0] val;
    int                    r;
    foreach (value_pool[k]) value_pool[k] = $urandom();
    repeat (n) begin
      if ($urandom_range(0, 99) < push_pct) begin
        act = ACT_PUSH;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) act = ACT_POP;
        else if (r < 95) act = ACT_REMOVE;
        else act = ACT_CLEAR;
      end
      if ($urandom_range(0, 99) < 80) val = value_pool[$urandom_range(0, 7)];
      else val = $urandom();
      queue_item(act, val);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Out of reset the capacity is zero: every action must fail.
    queue_item(ACT_PUSH, 32'h1234_5678);
    queue_item(ACT_POP, 32'h0);
    queue_item(ACT_REMOVE, 32'h1234_5678);
    queue_item(ACT_CLEAR, 32'h0);

    // Small queue: fill to full, remove from the middle, head and tail,
    // miss on remove, drain past empty and clear both non-empty and empty.
    write_capacity(5'd3);
    queue_item(ACT_PUSH, 32'h0000_0000);
    queue_item(ACT_PUSH, 32'hFFFF_FFFF);
    queue_item(ACT_PUSH, 32'h0000_0005);
    queue_item(ACT_PUSH, 32'h0000_0007);
    queue_item(ACT_REMOVE, 32'hFFFF_FFFF);
    queue_item(ACT_REMOVE, 32'h0000_0009);
    queue_item(ACT_PUSH, 32'h0000_0000);
    queue_item(ACT_REMOVE, 32'h0000_0000);
    queue_item(ACT_REMOVE, 32'h0000_0000);
    queue_item(ACT_PUSH, 32'hAAAA_AAAA);
    queue_item(ACT_POP, 32'hFFFF_FFFF);
    queue_item(ACT_POP, 32'h0);
    queue_item(ACT_POP, 32'h0);
    queue_item(ACT_REMOVE, 32'h0000_0001);
    queue_item(ACT_PUSH, 32'h5555_5555);
    queue_item(ACT_CLEAR, 32'h0);
    queue_item(ACT_POP, 32'h0);
    queue_item(ACT_CLEAR, 32'h0);

    // Full pool, with a long sink hold-off so the block backs up and
    // stalls its input while the driver keeps offering.
    write_capacity(5'd16);
    queue_random(200, 55);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;

    // Single slot: nearly every other push hits a full queue.
    write_capacity(5'd1);
    queue_random(100, 50);

    // Largest register value acts as the pool depth; run without idling.
    write_capacity(5'd31);
    calm_phase = 1'b1;
    queue_random(150, 70);
    wait_quiet();
    calm_phase = 1'b0;

    write_capacity(5'd0);
    queue_random(30, 50);

    write_capacity(5'd17);
    queue_random(100, 65);

    mid_cap = $urandom_range(2, 15);
    write_capacity(CAP_W'(mid_cap));
    queue_random(160, 50);

    write_capacity(5'd16);
    queue_random(140, 45);

    // Drain, then leave room for a late remove to surface.
    wait_quiet();
    repeat (POOL_DEPTH + 4) @(posedge clk_i);
    $display("tb: %0d transactions in, %0d results checked (%0d succeeded, %0d failed)",
             items_taken, results_checked, ok_total, fail_total);
    $display("tb: capacities 0, 3, 16, 1, 31, 0, 17, %0d and 16, with a long sink hold-off",
             mid_cap);
    if (fault_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
